/* rtl/pgrep_pkg.sv */
// Shared types and constants for the page replacement frame table.
package pgrep_pkg;

    localparam int CNT_BITS = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int POLICY_W = 2;
    localparam int FRAMES_W = 4;
    localparam int PAGE_IN_W = 16;
    localparam int FRAME_OUT_W = 3;

    typedef logic [CNT_BITS-1:0] t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [POLICY_W-1:0] t_policy;

    localparam t_cfg_idx REG_POLICY = 2'd0;
    localparam t_cfg_idx REG_FRAMES = 2'd1;

    localparam t_policy POL_FIFO = 2'd0;
    localparam t_policy POL_LRU = 2'd1;
    localparam t_policy POL_LFU = 2'd2;

    localparam t_count SAT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE
    } t_state;

    function automatic t_count sat_inc(input t_count v);
        return (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

/* rtl/pgrep_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pgrep_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pgrep_scan.sv */
// Per-entry scan tracker: first match, first empty frame, LRU and LFU minimum.
module pgrep_scan #(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic                          i_chk,
    input  logic [$clog2(NUM_FRAMES)-1:0] i_chk_idx,
    input  logic                          i_chk_valid,
    input  logic [PAGE_BITS-1:0]          i_ref_page,
    input  logic [PAGE_BITS-1:0]          i_rd_page,
    input  pgrep_pkg::t_count             i_rd_time,
    input  pgrep_pkg::t_count             i_rd_cnt,
    output logic                          o_hit_found,
    output logic [$clog2(NUM_FRAMES)-1:0] o_hit_idx,
    output pgrep_pkg::t_count             o_hit_cnt,
    output logic                          o_empty_found,
    output logic [$clog2(NUM_FRAMES)-1:0] o_empty_idx,
    output logic [$clog2(NUM_FRAMES)-1:0] o_lru_idx,
    output logic [$clog2(NUM_FRAMES)-1:0] o_lfu_idx
);
    import pgrep_pkg::*;

    localparam int IDX_W = $clog2(NUM_FRAMES);

    logic             r_hit_found;
    logic [IDX_W-1:0] r_hit_idx;
    t_count           r_hit_cnt;
    logic             r_empty_found;
    logic [IDX_W-1:0] r_empty_idx;
    logic [IDX_W-1:0] r_lru_idx;
    logic [IDX_W-1:0] r_lfu_idx;
    t_count           r_min_time;
    t_count           r_min_cnt;
    logic             w_first;

    assign w_first = (i_chk_idx == '0);

    // Flags restart per request; LRU and LFU indexes and minima are overwritten by entry 0.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (i_chk) begin
            if (i_chk_valid && (i_rd_page == i_ref_page) && !r_hit_found) begin
                r_hit_found <= 1'b1;
            end
            if (!i_chk_valid && !r_empty_found) begin
                r_empty_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_chk) begin
            if (i_chk_valid && (i_rd_page == i_ref_page) && !r_hit_found) begin
                r_hit_idx <= i_chk_idx;
                r_hit_cnt <= i_rd_cnt;
            end
            if (!i_chk_valid && !r_empty_found) begin
                r_empty_idx <= i_chk_idx;
            end
            // strict less keeps the lowest index on ties
            if (w_first || (i_rd_time < r_min_time)) begin
                r_min_time <= i_rd_time;
                r_lru_idx  <= i_chk_idx;
            end
            if (w_first || (i_rd_cnt < r_min_cnt)) begin
                r_min_cnt <= i_rd_cnt;
                r_lfu_idx <= i_chk_idx;
            end
        end
    end

    assign o_hit_found   = r_hit_found;
    assign o_hit_idx     = r_hit_idx;
    assign o_hit_cnt     = r_hit_cnt;
    assign o_empty_found = r_empty_found;
    assign o_empty_idx   = r_empty_idx;
    assign o_lru_idx     = r_lru_idx;
    assign o_lfu_idx     = r_lfu_idx;

endmodule

/* rtl/page_replacement_fifo_lru_lfu_core.sv */
// Page replacement frame table (FIFO / LRU / LFU) top level with request sequencer.
// Requests are taken one at a time, only in the idle state, and pass through the scan,
// decide and write states before the result is valid; the frame scan
// reads one table entry per cycle from the single-port-read frame RAM.
// Reset (synchronous, active low) clears valid bits, counters, FIFO pointer and
// config (policy FIFO, 8 frames); the frame RAM is not cleared, valid bits mask it.
module page_replacement_fifo_lru_lfu_core #(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  pgrep_pkg::t_cfg_idx             i_cfg_index,
    input  pgrep_pkg::t_cfg_data            i_cfg_data,
    // reference input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pgrep_pkg::PAGE_IN_W-1:0] i_page_number,
    input  logic                            i_last_in_string,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic [pgrep_pkg::FRAME_OUT_W-1:0] o_frame_index,
    output pgrep_pkg::t_count                 o_fault_count,
    output pgrep_pkg::t_count                 o_hit_count,
    output logic                              o_end_of_string
);
    import pgrep_pkg::*;

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
    localparam int WORD_W = PAGE_BITS + 2 * CNT_BITS;

    // RAM word layout: {page, last use time, use count}
    localparam int TIME_LO = CNT_BITS;
    localparam int PAGE_LO = 2 * CNT_BITS;

    t_state r_state, n_state;

    // config registers
    t_policy             r_policy;
    logic [FRAMES_W-1:0] r_frames;

    // table state held in flops
    logic [NUM_FRAMES-1:0] r_valid;
    logic [IDX_W-1:0]      r_fifo;
    t_count                r_faults;
    t_count                r_hits;

    // request context
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_last;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_chk;
    logic [IDX_W-1:0]     r_chk_idx;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_sel_idx;
    t_count               r_new_cnt;

    // output register
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [FRAME_OUT_W-1:0] r_out_idx;
    t_count                 r_out_faults;
    t_count                 r_out_hits;
    logic                   r_out_eos;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_wr_go;
    logic             w_in_stall;
    logic [IDX_W-1:0] w_raddr;
    logic             w_rd_issue;
    logic [CNT_W-1:0] w_active;
    logic [IDX_W-1:0] w_victim;
    logic [IDX_W-1:0] w_sel;
    logic [CNT_BITS:0] w_sum;
    t_count           w_time;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_rdata;

    logic             s_hit_found;
    logic [IDX_W-1:0] s_hit_idx;
    t_count           s_hit_cnt;
    logic             s_empty_found;
    logic [IDX_W-1:0] s_empty_idx;
    logic [IDX_W-1:0] s_lru_idx;
    logic [IDX_W-1:0] s_lfu_idx;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !w_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    // the write step waits only if the previous result is still held
    assign w_wr_go     = (r_state == ST_WRITE) && (!r_out_valid || !i_out_stall);

    // active frame count: 0 acts as 1, clipped at the table size
    always_comb begin
        if (r_frames == '0) begin
            w_active = CNT_W'(1);
        end else if (32'(r_frames) > NUM_FRAMES) begin
            w_active = CNT_W'(NUM_FRAMES);
        end else begin
            w_active = CNT_W'(r_frames);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_n) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_wr_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_stall = 1'b1;
        w_rd_issue = 1'b0;
        w_raddr    = r_idx[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                w_in_stall = 1'b0;
            end
            ST_SCAN: begin
                w_rd_issue = (r_idx < r_n);
            end
            ST_DECIDE: begin
                w_in_stall = 1'b1;
            end
            ST_WRITE: begin
                w_in_stall = 1'b1;
            end
            default: begin
                w_in_stall = 1'b1;
            end
        endcase
    end

    assign o_in_stall = w_in_stall;

    // frame choice: the hit frame, else the first empty frame, else the policy's victim
    always_comb begin
        case (r_policy)
            POL_LRU: w_victim = s_lru_idx;
            POL_LFU: w_victim = s_lfu_idx;
            default: w_victim = (CNT_W'(r_fifo) < r_n) ? r_fifo : '0;
        endcase
        if (s_hit_found) begin
            w_sel = s_hit_idx;
        end else if (s_empty_found) begin
            w_sel = s_empty_idx;
        end else begin
            w_sel = w_victim;
        end
    end

    // time stamp from the counts that include this request
    assign w_sum   = {1'b0, r_faults} + {1'b0, r_hits};
    assign w_time  = w_sum[CNT_BITS] ? SAT_MAX : w_sum[CNT_BITS-1:0];
    assign w_wdata = {r_page, w_time, r_new_cnt};

    pgrep_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_go),
        .i_waddr (r_sel_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pgrep_scan #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_start       (w_in_acc),
        .i_chk         (r_chk),
        .i_chk_idx     (r_chk_idx),
        .i_chk_valid   (r_valid[r_chk_idx]),
        .i_ref_page    (r_page),
        .i_rd_page     (w_rdata[PAGE_LO +: PAGE_BITS]),
        .i_rd_time     (w_rdata[TIME_LO +: CNT_BITS]),
        .i_rd_cnt      (w_rdata[CNT_BITS-1:0]),
        .o_hit_found   (s_hit_found),
        .o_hit_idx     (s_hit_idx),
        .o_hit_cnt     (s_hit_cnt),
        .o_empty_found (s_empty_found),
        .o_empty_idx   (s_empty_idx),
        .o_lru_idx     (s_lru_idx),
        .o_lfu_idx     (s_lfu_idx)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_policy    <= POL_FIFO;
            r_frames    <= FRAMES_W'(8);
            r_valid     <= '0;
            r_fifo      <= '0;
            r_faults    <= '0;
            r_hits      <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= w_rd_issue;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_POLICY: r_policy <= i_cfg_data[POLICY_W-1:0];
                    REG_FRAMES: r_frames <= i_cfg_data[FRAMES_W-1:0];
                    default: ;
                endcase
            end

            // commit hit/fault bookkeeping once the scan is done
            if (r_state == ST_DECIDE) begin
                if (s_hit_found) begin
                    r_hits <= sat_inc(r_hits);
                end else begin
                    r_faults <= sat_inc(r_faults);
                    r_fifo   <= ((CNT_W'(w_sel) + CNT_W'(1)) == r_n) ?
                                '0 : w_sel + IDX_W'(1);
                end
            end

            if (w_wr_go) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    // end of string: table and counters back to reset
                    r_valid  <= '0;
                    r_fifo   <= '0;
                    r_faults <= '0;
                    r_hits   <= '0;
                end else begin
                    r_valid[r_sel_idx] <= 1'b1;
                end
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_page <= PAGE_BITS'(i_page_number);
            r_last <= i_last_in_string;
            r_n    <= w_active;
            r_idx  <= '0;
        end else if (r_state == ST_SCAN && r_idx < r_n) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (w_rd_issue) begin
            r_chk_idx <= r_idx[IDX_W-1:0];
        end
        if (r_state == ST_DECIDE) begin
            r_hit     <= s_hit_found;
            r_sel_idx <= w_sel;
            r_new_cnt <= s_hit_found ? sat_inc(s_hit_cnt) : t_count'(1);
        end
        if (w_wr_go) begin
            r_out_hit    <= r_hit;
            r_out_idx    <= FRAME_OUT_W'(r_sel_idx);
            r_out_faults <= r_faults;
            r_out_hits   <= r_hits;
            r_out_eos    <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_idx;
    assign o_fault_count   = r_out_faults;
    assign o_hit_count     = r_out_hits;
    assign o_end_of_string = r_out_eos;

endmodule

/* rtl/pgrep_chk.sv */
// Port-level checker for the page replacement frame table, bound to the top level.
module pgrep_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_hit,
    input logic [pgrep_pkg::FRAME_OUT_W-1:0] o_frame_index,
    input pgrep_pkg::t_count                 o_fault_count,
    input pgrep_pkg::t_count                 o_hit_count,
    input logic                              o_end_of_string
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit) &&
        $stable(o_frame_index) && $stable(o_fault_count) && $stable(o_hit_count) &&
        $stable(o_end_of_string))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a fault is always counted in its own result
    a_fault_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_fault_count != '0)
        else $error("fault result with zero fault count");

    // a hit is always counted in its own result
    a_hit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_hit_count != '0)
        else $error("hit result with zero hit count");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind page_replacement_fifo_lru_lfu_core pgrep_chk u_pgrep_chk (.*);
